FILE: design/assert_macros.svh
// Assertion macros shared by the sparse triplet merge-add design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Implication property, checked on each rising edge outside reset.
`define STM_ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("stm assertion failed");
// Invariant that holds at every rising edge outside reset.
`define STM_ASSERT_INV(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("stm invariant failed");
`else
`define STM_ASSERT_PROP(lbl, clk, rst_n, prop)
`define STM_ASSERT_INV(lbl, clk, rst_n, expr)
`endif

`endif

FILE: design/stm_pkg.sv
// Shared constants, types and codes of the sparse triplet merge-add unit.
`default_nettype none
package stm_pkg;

    // Store depth and index width
    localparam int MAX_ENTRIES = 32;
    localparam int INDEX_BITS  = 10;

    // Fixed field widths
    localparam int ROW_W = 10;
    localparam int VAL_W = 32;
    localparam int TOT_W = 7;

    // Derived widths
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    // Stream payload widths
    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = 2;

    // Mask applied to row and column on load
    localparam logic [ROW_W-1:0] IDX_MASK = ROW_W'((64'd1 << INDEX_BITS) - 64'd1);

    // Operation codes carried in the input tuser
    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_MERGE  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    // One stored triplet
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic [VAL_W-1:0] value;
    } t_trip;

    // Decision of the shared compare/add unit for one merge step
    typedef struct packed {
        logic  done;
        logic  take_a;
        logic  take_b;
        logic  emit;
        t_trip trip;
    } t_alu_res;

endpackage
`default_nettype wire

FILE: design/sparse_triplet_merge_add_unit.sv
// Sparse matrix adder: two triplet stores, merge sequencer and output register.
//
// Loads (tuser 0 and 1) each append one triplet to the first or second
// store; a load into a full store is dropped and flagged.
// A merge (tuser 2) walks both stores with two pointers through one shared
// compare/add unit. Each merge step first reads the heads from the stores
// (registered read port, S_FETCH), then decides and advances (S_STEP); the
// input stays busy for the whole merge, which takes fewer steps when
// positions match and lasts longer while the output beat is stalled.
// One result is held back so that the final beat can carry tlast and the
// total count; an empty sum gives a single beat with has_entry low. The merge
// empties both stores. The input is ready only while no merge is running.
`default_nettype none
`include "assert_macros.svh"
module sparse_triplet_merge_add_unit
    import stm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [9:0] entry_row, [19:10] entry_col, [51:20] entry_value, [55:52] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] operation
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [9:0] out_row, [19:10] out_col, [51:20] out_value,
    // [58:52] total_count, [63:59] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // [0] has_entry, [1] load_dropped
    output logic [OUT_USER_W-1:0]      m_axis_tuser,
    output logic                       m_axis_tlast
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_STEP,
        S_FINISH
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_cnt_a;
    logic [CNT_W-1:0]   r_cnt_b;
    logic               r_ovf;
    logic [CNT_W-1:0]   r_i;
    logic [CNT_W-1:0]   r_j;
    logic [TOT_W-1:0]   r_k;
    t_trip              r_pend;
    logic               r_pend_v;

    // Output register
    logic               r_ov;
    t_trip              r_out;
    logic               r_out_has;
    logic               r_out_last;
    logic [TOT_W-1:0]   r_out_tot;
    logic               r_out_drop;

    logic               in_acc;
    t_op                op;
    t_trip              in_trip;
    logic               full_a;
    logic               full_b;
    logic               we_a;
    logic               we_b;
    t_trip              rd_a;
    t_trip              rd_b;
    t_alu_res           alu;
    logic               out_free;
    logic               out_load;

    // Input decode
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign op            = t_op'(s_axis_tuser);
    assign in_trip.row   = s_axis_tdata[ROW_W-1:0] & IDX_MASK;
    assign in_trip.col   = s_axis_tdata[2*ROW_W-1:ROW_W] & IDX_MASK;
    assign in_trip.value = s_axis_tdata[2*ROW_W+VAL_W-1:2*ROW_W];
    assign full_a        = (r_cnt_a >= CNT_W'(MAX_ENTRIES));
    assign full_b        = (r_cnt_b >= CNT_W'(MAX_ENTRIES));
    assign we_a          = in_acc && (op == OP_LOAD_A) && !full_a;
    assign we_b          = in_acc && (op == OP_LOAD_B) && !full_b;
    assign out_free      = !r_ov || m_axis_tready;

    // A new beat enters the output register this cycle
    assign out_load = ((r_state == S_STEP) && !alu.done && alu.emit && r_pend_v && out_free)
                   || ((r_state == S_FINISH) && out_free);

    // Triplet stores
    stm_store_ram u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[ADDR_W-1:0]),
        .i_wdata (in_trip),
        .i_raddr (r_i[ADDR_W-1:0]),
        .o_rdata (rd_a)
    );

    stm_store_ram u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[ADDR_W-1:0]),
        .i_wdata (in_trip),
        .i_raddr (r_j[ADDR_W-1:0]),
        .o_rdata (rd_b)
    );

    // Shared compare/add unit
    stm_merge_alu u_alu (
        .i_a     (rd_a),
        .i_b     (rd_b),
        .i_a_has (r_i < r_cnt_a),
        .i_b_has (r_j < r_cnt_b),
        .o_res   (alu)
    );

    // Sequencer, counts and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_ovf    <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (op)
                            OP_LOAD_A: begin
                                if (full_a) begin
                                    r_ovf <= 1'b1;
                                end else begin
                                    r_cnt_a <= r_cnt_a + 1'b1;
                                end
                            end
                            OP_LOAD_B: begin
                                if (full_b) begin
                                    r_ovf <= 1'b1;
                                end else begin
                                    r_cnt_b <= r_cnt_b + 1'b1;
                                end
                            end
                            OP_MERGE: begin
                                r_i      <= '0;
                                r_j      <= '0;
                                r_k      <= '0;
                                r_pend_v <= 1'b0;
                                r_state  <= S_FETCH;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_FETCH: begin
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    if (alu.done) begin
                        r_state <= S_FINISH;
                    end else if (!(alu.emit && r_pend_v && !out_free)) begin
                        // held result goes out, the new one is held back
                        if (alu.emit) begin
                            if (r_pend_v) begin
                                r_out      <= r_pend;
                                r_out_has  <= 1'b1;
                                r_out_last <= 1'b0;
                                r_out_tot  <= '0;
                                r_out_drop <= r_ovf;
                            end
                            r_pend   <= alu.trip;
                            r_pend_v <= 1'b1;
                            r_k      <= r_k + 1'b1;
                        end
                        if (alu.take_a) begin
                            r_i <= r_i + 1'b1;
                        end
                        if (alu.take_b) begin
                            r_j <= r_j + 1'b1;
                        end
                        r_state <= S_FETCH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_last <= 1'b1;
                        r_out_drop <= r_ovf;
                        if (r_pend_v) begin
                            r_out     <= r_pend;
                            r_out_has <= 1'b1;
                            r_out_tot <= r_k;
                        end else begin
                            r_out     <= '0;
                            r_out_has <= 1'b0;
                            r_out_tot <= '0;
                        end
                        r_pend_v <= 1'b0;
                        r_cnt_a  <= '0;
                        r_cnt_b  <= '0;
                        r_ovf    <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output beat
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {(OUT_DATA_W - 2*ROW_W - VAL_W - TOT_W)'(0), r_out_tot,
                            r_out.value, r_out.col, r_out.row};
    assign m_axis_tuser  = {r_out_drop, r_out_has};
    assign m_axis_tlast  = r_out_last;

    // Store fill never passes the depth
    `STM_ASSERT_INV(a_cnt_bound, i_clk, i_rst_n,
        (r_cnt_a <= CNT_W'(MAX_ENTRIES)) && (r_cnt_b <= CNT_W'(MAX_ENTRIES)))
    // Results found never exceed the entries walked
    `STM_ASSERT_INV(a_k_bound, i_clk, i_rst_n,
        ({1'b0, r_k} <= ((TOT_W+1)'(r_i) + (TOT_W+1)'(r_j))))
    // An empty-result beat is always the last one and counts zero
    `STM_ASSERT_PROP(a_empty_last, i_clk, i_rst_n,
        (r_ov && !r_out_has) |-> (r_out_last && (r_out_tot == '0)))
    // Finishing a merge empties both stores and the drop flag
    `STM_ASSERT_PROP(a_merge_clears, i_clk, i_rst_n,
        (r_state == S_FINISH && out_free) |=>
        ((r_cnt_a == '0) && (r_cnt_b == '0) && !r_ovf && r_out_last))

endmodule
`default_nettype wire

FILE: design/stm_store_ram.sv
// Triplet store: one write port, one read port with registered read data.
`default_nettype none
module stm_store_ram
    import stm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire t_trip             i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output t_trip                  o_rdata
);

    t_trip r_mem [MAX_ENTRIES];
    t_trip r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: design/stm_merge_alu.sv
// Shared compare/add unit: decides one merge step from the two head entries.
`default_nettype none
module stm_merge_alu
    import stm_pkg::*;
(
    input  wire t_trip  i_a,
    input  wire t_trip  i_b,
    input  wire logic   i_a_has,
    input  wire logic   i_b_has,
    output t_alu_res    o_res
);

    logic [2*ROW_W-1:0] key_a;
    logic [2*ROW_W-1:0] key_b;
    logic [VAL_W-1:0]   sum;

    assign key_a = {i_a.row, i_a.col};
    assign key_b = {i_b.row, i_b.col};
    assign sum   = i_a.value + i_b.value;

    // Row-major ordering; equal positions add, a zero sum is dropped
    always_comb begin
        o_res        = '0;
        o_res.done   = !i_a_has && !i_b_has;
        if (i_a_has && i_b_has) begin
            if (key_a < key_b) begin
                o_res.take_a = 1'b1;
                o_res.emit   = 1'b1;
                o_res.trip   = i_a;
            end else if (key_b < key_a) begin
                o_res.take_b = 1'b1;
                o_res.emit   = 1'b1;
                o_res.trip   = i_b;
            end else begin
                o_res.take_a     = 1'b1;
                o_res.take_b     = 1'b1;
                o_res.emit       = (sum != '0);
                o_res.trip.row   = i_a.row;
                o_res.trip.col   = i_a.col;
                o_res.trip.value = sum;
            end
        end else if (i_a_has) begin
            o_res.take_a = 1'b1;
            o_res.emit   = 1'b1;
            o_res.trip   = i_a;
        end else if (i_b_has) begin
            o_res.take_b = 1'b1;
            o_res.emit   = 1'b1;
            o_res.trip   = i_b;
        end
    end

endmodule
`default_nettype wire

FILE: tb/sv/sparse_triplet_merge_add_unit_test.sv
`timescale 1ns / 1ps
// Stream testbench of the sparse triplet merge-add unit, with its own sum predictor and checker.
module sparse_triplet_merge_add_unit_test;
    import stm_pkg::*;

    // One load or command beat as queued for the driver
    typedef struct packed {
        t_op              op;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic [VAL_W-1:0] value;
        logic             drain;    // hold this beat until every sum beat is back
    } t_load;

    // One predicted output beat of a merge
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic [VAL_W-1:0] value;
        logic             has_entry;
        logic             is_last;
        logic [TOT_W-1:0] total;
        logic             dropped;
    } t_sum_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    wire                   s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    wire                   m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    wire  [OUT_DATA_W-1:0] m_axis_tdata;
    wire  [OUT_USER_W-1:0] m_axis_tuser;
    wire                   m_axis_tlast;

    // Stimulus and scoreboard state
    t_load     load_queue[$];
    t_load     cur_load;
    t_sum_beat sums_due[$];
    int        useful_items = 0;
    int        beats_sent = 0;
    int        mismatches = 0;
    logic      beat_taken = 1'b0;
    wire       calm = (beats_sent >= 120) && (beats_sent < 200);

    // Predictor copy of the two triplet stores
    t_trip     first_trips[MAX_ENTRIES];
    t_trip     second_trips[MAX_ENTRIES];
    int        first_cnt = 0;
    int        second_cnt = 0;
    logic      dropped_flag = 1'b0;

    sparse_triplet_merge_add_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_sum_beat trip_beat(input t_trip t, input logic has);
        t_sum_beat b;
        b.row       = t.row;
        b.col       = t.col;
        b.value     = t.value;
        b.has_entry = has;
        b.is_last   = 1'b0;
        b.total     = '0;
        b.dropped   = dropped_flag;
        return b;
    endfunction

    // Apply one accepted beat to the predicted stores; a merge queues its sum beats
    task automatic add_into_sums(input t_load it);
        t_sum_beat          pend[$];
        t_sum_beat          r;
        t_trip              a;
        t_trip              b;
        logic [VAL_W-1:0]   s;
        logic [2*ROW_W-1:0] ka;
        logic [2*ROW_W-1:0] kb;
        int                 i;
        int                 j;
        int                 k;
        i = 0;
        j = 0;
        case (it.op)
            OP_LOAD_A: begin
                if (first_cnt >= MAX_ENTRIES) dropped_flag = 1'b1;
                else begin
                    first_trips[first_cnt] = {it.row & IDX_MASK, it.col & IDX_MASK, it.value};
                    first_cnt++;
                end
            end
            OP_LOAD_B: begin
                if (second_cnt >= MAX_ENTRIES) dropped_flag = 1'b1;
                else begin
                    second_trips[second_cnt] = {it.row & IDX_MASK, it.col & IDX_MASK, it.value};
                    second_cnt++;
                end
            end
            OP_MERGE: begin
                // two-pointer walk, lesser position first, equal positions summed
                while (i < first_cnt || j < second_cnt) begin
                    if (i < first_cnt) begin
                        a  = first_trips[i];
                        ka = {a.row, a.col};
                    end
                    if (j < second_cnt) begin
                        b  = second_trips[j];
                        kb = {b.row, b.col};
                    end
                    if (j >= second_cnt || (i < first_cnt && ka < kb)) begin
                        pend.push_back(trip_beat(a, 1'b1));
                        i++;
                    end else if (i >= first_cnt || kb < ka) begin
                        pend.push_back(trip_beat(b, 1'b1));
                        j++;
                    end else begin
                        s = a.value + b.value;
                        if (s != '0) pend.push_back(trip_beat({a.row, a.col, s}, 1'b1));
                        i++;
                        j++;
                    end
                end
                k = pend.size();
                if (k == 0) pend.push_back(trip_beat('0, 1'b0));
                r = pend.pop_back();
                r.is_last = 1'b1;
                r.total   = TOT_W'(k);
                pend.push_back(r);
                foreach (pend[n]) sums_due.push_back(pend[n]);
                first_cnt    = 0;
                second_cnt   = 0;
                dropped_flag = 1'b0;
            end
            default: ;
        endcase
    endtask

    function automatic void check_field(input string name, input logic [31:0] got,
                                        input logic [31:0] want);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endfunction

    // Driver: new beats and ready change on the falling edge
    always @(negedge i_clk) begin : drive_beats
        if (i_rst_n) begin
            if (!s_axis_tvalid || beat_taken) begin
                if (load_queue.size() != 0 && !(load_queue[0].drain && sums_due.size() != 0)
                    && (calm || $urandom_range(0, 99) >= 18)) begin
                    cur_load = load_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {4'b0, cur_load.value, cur_load.col, cur_load.row};
                    s_axis_tuser  <= cur_load.op;
                    beats_sent++;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 18);
        end
    end

    // Monitor: predict on input beats, check output beats, both at the rising edge
    always @(posedge i_clk) begin : watch_beats
        t_sum_beat want;
        beat_taken = s_axis_tvalid && s_axis_tready;
        if (beat_taken) add_into_sums(cur_load);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (sums_due.size() == 0) begin
                mismatches++;
                $display("%0t: sum beat expected none actual tdata %h tuser %b tlast %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end else begin
                want = sums_due.pop_front();
                check_field("out_row", m_axis_tdata[9:0], want.row);
                check_field("out_col", m_axis_tdata[19:10], want.col);
                check_field("out_value", m_axis_tdata[51:20], want.value);
                check_field("total_count", m_axis_tdata[58:52], want.total);
                check_field("has_entry", m_axis_tuser[0], want.has_entry);
                check_field("load_dropped", m_axis_tuser[1], want.dropped);
                check_field("is_last", m_axis_tlast, want.is_last);
            end
        end
    end

    task automatic queue_load(input t_op op, input logic [ROW_W-1:0] row,
                              input logic [ROW_W-1:0] col, input logic [VAL_W-1:0] value);
        load_queue.push_back({op, row, col, value, 1'b0});
        if (op != OP_NOP) useful_items++;
    endtask

    task automatic queue_merge(input logic drain);
        load_queue.push_back({OP_MERGE, {ROW_W{1'b0}}, {ROW_W{1'b0}}, {VAL_W{1'b0}}, drain});
        useful_items++;
    endtask

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Two sorted lists over a shared key sequence, loads interleaved, then a merge
    task automatic queue_sum_case(input int nkeys, input int step_max, input logic drain);
        t_trip a_trips[$];
        t_trip b_trips[$];
        t_trip t;
        int    key;
        int    pick;
        logic [VAL_W-1:0] v;
        key = $urandom_range(0, 3000);
        for (int n = 0; n < nkeys; n++) begin
            pick = $urandom_range(0, 2);    // first only, second only, or both
            v = rand_value();
            if (pick != 1) a_trips.push_back({key[19:10], key[9:0], v});
            if (pick != 0) begin
                // same position: often the negated value so the sum cancels
                if (pick == 2 && $urandom_range(0, 3) == 0) v = -v;
                else v = rand_value();
                b_trips.push_back({key[19:10], key[9:0], v});
            end
            key = key + $urandom_range(1, step_max);
        end
        while (a_trips.size() != 0 || b_trips.size() != 0) begin
            if ($urandom_range(0, 19) == 0)
                queue_load(OP_NOP, ROW_W'($urandom), ROW_W'($urandom), $urandom);
            if (b_trips.size() == 0 || (a_trips.size() != 0 && $urandom_range(0, 1) == 1)) begin
                t = a_trips.pop_front();
                queue_load(OP_LOAD_A, t.row, t.col, t.value);
            end else begin
                t = b_trips.pop_front();
                queue_load(OP_LOAD_B, t.row, t.col, t.value);
            end
        end
        queue_merge(drain);
    endtask

    // Unsorted, duplicate and ignored beats with random fields
    task automatic queue_noise(input int n);
        for (int m = 0; m < n; m++)
            queue_load(t_op'($urandom_range(0, 3)), ROW_W'($urandom), ROW_W'($urandom),
                       rand_value());
        if ($urandom_range(0, 1) == 1) queue_merge(1'b0);
    endtask

    // Stimulus, reset and end of run
    initial begin : run_test
        int pct;
        // empty sum
        queue_merge(1'b0);
        // wrapping sum, passed-through zero, cancelled pair at the far corner, ignored op
        queue_load(OP_LOAD_A, 10'd0, 10'd0, 32'h7FFF_FFFF);
        queue_load(OP_LOAD_A, 10'd0, 10'd1023, 32'h8000_0000);
        queue_load(OP_LOAD_A, 10'd1023, 10'd1023, 32'h8000_0000);
        queue_load(OP_LOAD_B, 10'd0, 10'd0, 32'h0000_0001);
        queue_load(OP_LOAD_B, 10'd0, 10'd5, 32'h0000_0000);
        queue_load(OP_LOAD_B, 10'd1023, 10'd1023, 32'h8000_0000);
        queue_load(OP_NOP, 10'd1023, 10'd1023, 32'hFFFF_FFFF);
        queue_merge(1'b0);
        // everything cancels: empty result after loads
        queue_load(OP_LOAD_A, 10'd5, 10'd5, 32'd7);
        queue_load(OP_LOAD_B, 10'd5, 10'd5, -32'sd7);
        queue_merge(1'b0);
        // unsorted and duplicate positions
        queue_load(OP_LOAD_A, 10'd3, 10'd3, 32'd1);
        queue_load(OP_LOAD_A, 10'd1, 10'd1, 32'd2);
        queue_load(OP_LOAD_A, 10'd1, 10'd1, 32'd3);
        queue_load(OP_LOAD_B, 10'd2, 10'd2, 32'd4);
        queue_load(OP_LOAD_B, 10'd0, 10'd0, 32'hFFFF_FFFF);
        queue_merge(1'b0);
        // alternating bit patterns
        queue_load(OP_LOAD_B, 10'h200, 10'h200, 32'h5555_5555);
        queue_load(OP_LOAD_A, 10'h2AA, 10'h155, 32'hAAAA_AAAA);
        queue_merge(1'b0);

        // both stores overfilled: 64 sum beats, all flagged, after a full drain
        for (int n = 0; n < MAX_ENTRIES + 2; n++) begin
            queue_load(OP_LOAD_A, 10'(n / 8), 10'((2 * n) % 16), rand_value());
            queue_load(OP_LOAD_B, 10'(n / 8), 10'((2 * n) % 16 + 1), rand_value());
        end
        queue_merge(1'b1);

        while (useful_items < 255) begin
            pct = $urandom_range(0, 99);
            if (pct < 5)
                queue_sum_case($urandom_range(20, 40), 20000, $urandom_range(0, 5) == 0);
            else if (pct < 75)
                queue_sum_case($urandom_range(0, 10),
                               ($urandom_range(0, 1) == 1) ? 4 : 60000,
                               $urandom_range(0, 5) == 0);
            else
                queue_noise($urandom_range(1, 8));
        end
        queue_merge(1'b0);

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all beats accepted and all sums back, then let a full merge time pass
        while (load_queue.size() != 0 || s_axis_tvalid || sums_due.size() != 0)
            @(negedge i_clk);
        repeat (150) @(negedge i_clk);
        if (mismatches == 0 && sums_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
